FILE: src/bbfa_pkg.sv
// Shared types and constants for the bitmap best-fit block allocator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package bbfa_pkg;

  // Field widths of the input and result items.
  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned REQ_W = 9;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned TOT_W = 9;

  // Bitmap geometry and limits.
  localparam int unsigned MAP_W          = 32;
  localparam int unsigned SPAN_LIMIT     = 256;
  localparam int unsigned NUM_BLOCKS_DEF = 256;
  localparam logic [MAP_W-1:0] MAP_WORD0_RESET = 32'h0000_0001;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_BEST   = 2'd2,
    CMD_FORMAT = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_FRAG    = 3'd2,
    ST_NOSPACE = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new item and clear the scan state
    logic alloc_step;  // examine one bitmap word for a free block
    logic exec_op;     // perform a free or a format
    logic best_step;   // scan one byte of the bitmap for free runs
    logic best_close;  // close the last open run
    logic reply_load;  // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_err;   // latched index lies beyond the span
    logic alloc_hit;   // current word holds a free block
    logic word_last;   // word pointer is on the last word
    logic byte_last;   // byte pointer is on the last byte
  } ctrl_sts_t;

endpackage

FILE: src/bbfa_ctrl.sv
// Controller state machine of the bitmap best-fit block allocator.
// Depends on bbfa_pkg; drives the datapath through ctrl_cmd_t.
module bbfa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [bbfa_pkg::CMD_W-1:0] cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  bbfa_pkg::ctrl_sts_t   sts_i,
  output bbfa_pkg::ctrl_cmd_t   cmd_o
);
  import bbfa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALLOC = 6'b000010,
    S_EXEC  = 6'b000100,
    S_BEST  = 6'b001000,
    S_CLOSE = 6'b010000,
    S_REPLY = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;
  logic   out_xfer;
  cmd_e   new_cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_xfer    = out_valid_q & out_ready_i;
  assign new_cmd     = cmd_e'(cmd_i);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          case (new_cmd)
            CMD_ALLOC:  state_d = S_ALLOC;
            CMD_BEST:   state_d = S_BEST;
            CMD_FREE:   state_d = S_EXEC;
            CMD_FORMAT: state_d = S_EXEC;
            default:    state_d = S_EXEC;
          endcase
        end
      end
      S_ALLOC: begin
        if (sts_i.range_err) begin
          state_d = S_REPLY;
        end else begin
          cmd_o.alloc_step = 1'b1;
          if (sts_i.alloc_hit || sts_i.word_last) begin
            state_d = S_REPLY;
          end
        end
      end
      S_EXEC: begin
        cmd_o.exec_op = 1'b1;
        state_d       = S_REPLY;
      end
      S_BEST: begin
        cmd_o.best_step = 1'b1;
        if (sts_i.byte_last) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd_o.best_close = 1'b1;
        state_d          = S_REPLY;
      end
      S_REPLY: begin
        // Wait until the result register is free or is being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.reply_load = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.reply_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/bbfa_datapath.sv
// Datapath of the bitmap best-fit block allocator: bitmap, scan pointers,
// run tracking and the result register. Depends on bbfa_pkg.
module bbfa_datapath #(
  parameter int unsigned NUM_BLOCKS = bbfa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bbfa_pkg::CMD_W-1:0]  cmd_i,
  input  logic [bbfa_pkg::IDX_W-1:0]  block_index_i,
  input  logic [bbfa_pkg::REQ_W-1:0]  request_blocks_i,
  input  bbfa_pkg::ctrl_cmd_t         ctrl_cmd_i,
  output bbfa_pkg::ctrl_sts_t         sts_o,
  output logic [bbfa_pkg::ST_W-1:0]   status_o,
  output logic [bbfa_pkg::IDX_W-1:0]  result_index_o,
  output logic [bbfa_pkg::TOT_W-1:0]  free_total_o
);
  import bbfa_pkg::*;

  localparam int unsigned SPAN       = (NUM_BLOCKS < SPAN_LIMIT) ? NUM_BLOCKS : SPAN_LIMIT;
  localparam int unsigned SPAN_WORDS = (SPAN + MAP_W - 1) / MAP_W;
  localparam int unsigned SPAN_BYTES = (SPAN + 7) / 8;
  localparam int unsigned WORD_W     = (SPAN_WORDS > 1) ? $clog2(SPAN_WORDS) : 1;
  localparam int unsigned BYTE_W     = $clog2(SPAN_BYTES);
  localparam logic [TOT_W-1:0] SPAN_V = TOT_W'(SPAN);

  // Bitmap, one bit per block, 1 = used.
  logic [MAP_W-1:0] map_q [SPAN_WORDS];

  // Latched item.
  cmd_e             cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [REQ_W-1:0] req_q;

  // Scan pointers.
  logic [WORD_W-1:0] word_ptr_q;
  logic [BYTE_W-1:0] byte_ptr_q;

  // Allocation outcome.
  logic             alloc_found_q;
  logic [IDX_W-1:0] alloc_idx_q;

  // Best-fit run tracking.
  logic [TOT_W-1:0] run_len_q, run_len_d;
  logic [IDX_W-1:0] run_start_q, run_start_d;
  logic [TOT_W-1:0] best_diff_q, best_diff_d;
  logic [IDX_W-1:0] best_start_q, best_start_d;
  logic             found_q, found_d;
  logic [TOT_W-1:0] total_q;

  // Result register.
  logic [ST_W-1:0]  res_status_q;
  logic [IDX_W-1:0] res_index_q;
  logic [TOT_W-1:0] res_total_q;

  logic             range_err;
  logic [TOT_W-1:0] word_base;
  logic [MAP_W-1:0] word_used;
  logic             alloc_hit;
  logic [4:0]       alloc_pos;
  logic [TOT_W-1:0] byte_base;
  logic [WORD_W-1:0] byte_word;
  logic [MAP_W-1:0] byte_word_data;
  logic [7:0]       byte_used;
  logic [TOT_W-1:0] byte_free_cnt;
  status_e          rep_status;
  logic [IDX_W-1:0] rep_index;
  logic [TOT_W-1:0] rep_total;

  assign range_err = {1'b0, idx_q} >= SPAN_V;

  assign sts_o.range_err = range_err;
  assign sts_o.alloc_hit = alloc_hit;
  assign sts_o.word_last = (word_ptr_q == WORD_W'(SPAN_WORDS - 1));
  assign sts_o.byte_last = (byte_ptr_q == BYTE_W'(SPAN_BYTES - 1));

  // Allocation word: blocks below the hint or beyond the span count as used.
  assign word_base = TOT_W'(word_ptr_q) << 5;
  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      word_used[i] = map_q[word_ptr_q][i]
                   | ((word_base + TOT_W'(i)) < {1'b0, idx_q})
                   | ((word_base + TOT_W'(i)) >= SPAN_V);
    end
  end

  // First free block in the word, lowest index wins.
  always_comb begin
    alloc_hit = 1'b0;
    alloc_pos = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!word_used[i]) begin
        alloc_hit = 1'b1;
        alloc_pos = 5'(i);
      end
    end
  end

  // Byte of the bitmap under the best-fit scan; the close step feeds a used byte.
  assign byte_base      = TOT_W'({byte_ptr_q, 3'b000});
  assign byte_word      = WORD_W'(byte_ptr_q >> 2);
  assign byte_word_data = map_q[byte_word] >> {byte_ptr_q[1:0], 3'b000};
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      byte_used[k] = ctrl_cmd_i.best_close | byte_word_data[k]
                   | ((byte_base + TOT_W'(k)) >= SPAN_V);
    end
  end
  assign byte_free_cnt = TOT_W'($countones(~byte_used));

  // Run tracking over the eight bits of the byte.
  always_comb begin : run_walk
    logic [TOT_W-1:0] diff;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_diff_d  = best_diff_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    diff         = '0;
    for (int k = 0; k < 8; k++) begin
      if (!byte_used[k]) begin
        if (run_len_d == '0) begin
          run_start_d = IDX_W'(byte_base + TOT_W'(k));
        end
        run_len_d = run_len_d + 1'b1;
      end else if (run_len_d != '0) begin
        if (run_len_d >= req_q) begin
          diff = run_len_d - req_q;
          if (!found_d || (diff < best_diff_d)) begin
            found_d      = 1'b1;
            best_diff_d  = diff;
            best_start_d = run_start_d;
          end
        end
        run_len_d = '0;
      end
    end
  end

  // Reply fields for the latched command.
  always_comb begin
    rep_status = ST_OK;
    rep_index  = '0;
    rep_total  = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (range_err) begin
          rep_status = ST_RANGE;
        end else if (alloc_found_q) begin
          rep_index = alloc_idx_q;
        end else begin
          rep_status = ST_NOFREE;
        end
      end
      CMD_FREE: begin
        if (range_err) begin
          rep_status = ST_RANGE;
        end
      end
      CMD_BEST: begin
        rep_total = total_q;
        if (found_q) begin
          rep_index = best_start_q;
        end else if ((total_q < req_q) || (total_q == '0)) begin
          rep_status = ST_NOSPACE;
        end else begin
          rep_status = ST_FRAG;
        end
      end
      CMD_FORMAT: begin
        rep_status = ST_OK;
      end
      default: begin
        rep_status = ST_OK;
      end
    endcase
  end

  // Bitmap updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < SPAN_WORDS; w++) begin
        map_q[w] <= (w == 0) ? MAP_WORD0_RESET : '0;
      end
    end else begin
      if (ctrl_cmd_i.alloc_step && alloc_hit) begin
        map_q[word_ptr_q][alloc_pos] <= 1'b1;
      end
      if (ctrl_cmd_i.exec_op) begin
        if (cmd_q == CMD_FORMAT) begin
          for (int w = 0; w < SPAN_WORDS; w++) begin
            map_q[w] <= (w == 0) ? MAP_WORD0_RESET : '0;
          end
        end else if (!range_err) begin
          map_q[WORD_W'(idx_q >> 5)][idx_q[4:0]] <= 1'b0;
        end
      end
    end
  end

  // Item latch, scan pointers and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q         <= CMD_ALLOC;
      word_ptr_q    <= '0;
      byte_ptr_q    <= '0;
      alloc_found_q <= 1'b0;
      found_q       <= 1'b0;
      run_len_q     <= '0;
      total_q       <= '0;
    end else begin
      if (ctrl_cmd_i.load) begin
        cmd_q         <= cmd_e'(cmd_i);
        word_ptr_q    <= WORD_W'(block_index_i >> 5);
        byte_ptr_q    <= '0;
        alloc_found_q <= 1'b0;
        found_q       <= 1'b0;
        run_len_q     <= '0;
        total_q       <= '0;
      end
      if (ctrl_cmd_i.alloc_step) begin
        if (alloc_hit) begin
          alloc_found_q <= 1'b1;
        end else if (!sts_o.word_last) begin
          word_ptr_q <= word_ptr_q + 1'b1;
        end
      end
      if (ctrl_cmd_i.best_step || ctrl_cmd_i.best_close) begin
        run_len_q <= run_len_d;
        found_q   <= found_d;
        total_q   <= total_q + byte_free_cnt;
        if (!sts_o.byte_last) begin
          byte_ptr_q <= byte_ptr_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.load) begin
      idx_q <= block_index_i;
      req_q <= request_blocks_i;
    end
    if (ctrl_cmd_i.alloc_step && alloc_hit) begin
      alloc_idx_q <= IDX_W'(word_base + TOT_W'(alloc_pos));
    end
    if (ctrl_cmd_i.best_step || ctrl_cmd_i.best_close) begin
      run_start_q  <= run_start_d;
      best_diff_q  <= best_diff_d;
      best_start_q <= best_start_d;
    end
    if (ctrl_cmd_i.reply_load) begin
      res_status_q <= rep_status;
      res_index_q  <= rep_index;
      res_total_q  <= rep_total;
    end
  end

  assign status_o       = res_status_q;
  assign result_index_o = res_index_q;
  assign free_total_o   = res_total_q;

endmodule

FILE: src/bitmap_best_fit_block_allocator.sv
// Top level of the bitmap best-fit block allocator.
// Depends on bbfa_pkg, bbfa_ctrl and bbfa_datapath.
//
//   Channel  Direction  Handshake                  Payload
//   in       to block   in_valid_i / in_ready_o    cmd_i, block_index_i, request_blocks_i
//   out      from block out_valid_o / out_ready_i  status_o, result_index_o, free_total_o
//
// One item at a time. Free and format pass through the execute and reply states to the result.
// Allocate scans one 32-bit bitmap word a cycle from the hint word.
// Best-fit scans one byte of the bitmap a cycle, then closes the last run.
// Reset restores the map with block 0 used. A result waits in its register while
// the output stalls; the next item is taken once that result has been loaded.
module bitmap_best_fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = bbfa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bbfa_pkg::CMD_W-1:0] cmd_i,
  input  logic [bbfa_pkg::IDX_W-1:0] block_index_i,
  input  logic [bbfa_pkg::REQ_W-1:0] request_blocks_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bbfa_pkg::ST_W-1:0]  status_o,
  output logic [bbfa_pkg::IDX_W-1:0] result_index_o,
  output logic [bbfa_pkg::TOT_W-1:0] free_total_o
);
  import bbfa_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  // Sequencing of each command.
  bbfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  // Bitmap and scan logic.
  bbfa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_i),
    .block_index_i    (block_index_i),
    .request_blocks_i (request_blocks_i),
    .ctrl_cmd_i       (ctrl_cmd),
    .sts_o            (ctrl_sts),
    .status_o         (status_o),
    .result_index_o   (result_index_o),
    .free_total_o     (free_total_o)
  );

endmodule

FILE: src/bbfa_checker.sv
// Port-level checker for the bitmap best-fit block allocator, with its bind.
// Depends on bbfa_pkg and the top level bitmap_best_fit_block_allocator.
module bbfa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [bbfa_pkg::CMD_W-1:0] cmd_i,
  input logic [bbfa_pkg::IDX_W-1:0] block_index_i,
  input logic [bbfa_pkg::REQ_W-1:0] request_blocks_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bbfa_pkg::ST_W-1:0]  status_o,
  input logic [bbfa_pkg::IDX_W-1:0] result_index_o,
  input logic [bbfa_pkg::TOT_W-1:0] free_total_o
);
  import bbfa_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(result_index_o) && $stable(free_total_o)))
    else $error("stalled result changed");

  // Only one item is in work: the input closes after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input open right after a transfer");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_W'(ST_RANGE)))
    else $error("undefined status code");

  // A failed command reports block index zero.
  a_fail_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_W'(ST_OK))) |-> (result_index_o == '0))
    else $error("failure with nonzero index");

  // Only a best-fit query reports a free count; allocate and free failures do not.
  a_nofree_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == ST_W'(ST_NOFREE)) || (status_o == ST_W'(ST_RANGE))))
      |-> (free_total_o == '0))
    else $error("free count on allocate or free failure");

endmodule

bind bitmap_best_fit_block_allocator bbfa_checker u_bbfa_checker (.*);

FILE: tb/sv/bitmap_best_fit_block_allocator_tb.sv
// Self-checking testbench for the bitmap best-fit block allocator: a directed table,
// then random command phases checked against a behavioural bitmap predictor.
// Depends on bbfa_pkg and bitmap_best_fit_block_allocator.
module bitmap_best_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbfa_pkg::*;

  localparam int unsigned TB_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int unsigned TB_SPAN    = (TB_BLOCKS < SPAN_LIMIT) ? TB_BLOCKS : SPAN_LIMIT;
  localparam int          RAND_ITEMS = 1200;
  localparam int          CALM_LO    = 600;   // item numbers with no idling on either side
  localparam int          CALM_HI    = 800;
  localparam int          HOLD_AT    = 300;   // item number at which the output is held off
  localparam int          HOLD_LEN   = 400;
  localparam int          STALL_MAX  = 3000;  // cycles without any transfer before giving up
  localparam int          TAIL_LEN   = 60;
  localparam int          MAX_SHOWN  = 10;

  // One result item.
  typedef struct packed {
    status_e    status;
    logic [7:0] index;
    logic [8:0] total;
  } alloc_reply_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] idx;
    logic [8:0] req;
    bit         typed;
    status_e    st;
    logic [7:0] res;
    logic [8:0] tot;
  } stim_row_t;

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    '{CMD_BEST,   8'd0,   9'd0,   1'b1, ST_OK,      8'd1,   9'd255},
    '{CMD_BEST,   8'd255, 9'd255, 1'b1, ST_OK,      8'd1,   9'd255},
    '{CMD_BEST,   8'd0,   9'd256, 1'b1, ST_NOSPACE, 8'd0,   9'd255},
    '{CMD_ALLOC,  8'd0,   9'd0,   1'b1, ST_OK,      8'd1,   9'd0},
    '{CMD_ALLOC,  8'd255, 9'd256, 1'b1, ST_OK,      8'd255, 9'd0},
    '{CMD_ALLOC,  8'd255, 9'd0,   1'b1, ST_NOFREE,  8'd0,   9'd0},
    '{CMD_ALLOC,  8'd254, 9'd256, 1'b1, ST_OK,      8'd254, 9'd0},
    '{CMD_FREE,   8'd255, 9'd0,   1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_FREE,   8'd0,   9'd256, 1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_ALLOC,  8'd0,   9'd0,   1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_FREE,   8'd200, 9'd0,   1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_ALLOC,  8'd128, 9'd0,   1'b1, ST_OK,      8'd128, 9'd0},
    '{CMD_BEST,   8'd0,   9'd200, 1'b1, ST_FRAG,    8'd0,   9'd252},
    '{CMD_BEST,   8'd0,   9'd1,   1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd126, 1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd0,   1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd127, 1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_FORMAT, 8'd255, 9'd256, 1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_FREE,   8'd0,   9'd0,   1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd256, 1'b1, ST_OK,      8'd0,   9'd256},
    '{CMD_ALLOC,  8'd170, 9'd85,  1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_ALLOC,  8'd85,  9'd170, 1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_FORMAT, 8'd0,   9'd0,   1'b1, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd256, 1'b1, ST_NOSPACE, 8'd0,   9'd255},
    '{CMD_ALLOC,  8'd31,  9'd0,   1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_ALLOC,  8'd32,  9'd0,   1'b0, ST_OK,      8'd0,   9'd0},
    '{CMD_BEST,   8'd0,   9'd0,   1'b0, ST_OK,      8'd0,   9'd0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [IDX_W-1:0]     block_index_i;
  logic [REQ_W-1:0]     request_blocks_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ST_W-1:0]      status_o;
  logic [IDX_W-1:0]     result_index_o;
  logic [TOT_W-1:0]     free_total_o;

  // Predictor state: one bit per block, 1 = used.
  logic [SPAN_LIMIT-1:0] used_blocks;
  alloc_reply_t          pending_replies[$];
  int                    mismatches = 0;
  int                    items_sent = 0;
  int                    idle_cycles = 0;
  bit                    calm = 1'b0;
  bit                    hold_req = 1'b0;

  bitmap_best_fit_block_allocator #(
    .NUM_BLOCKS(TB_BLOCKS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .block_index_i   (block_index_i),
    .request_blocks_i(request_blocks_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_index_o  (result_index_o),
    .free_total_o    (free_total_o)
  );

  // Clock and initial input values.
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_FORMAT;
    block_index_i    = '0;
    request_blocks_i = '0;
  end

  always #1 clk_i = ~clk_i;

  // Clears the predicted map, keeping block 0 used.
  function automatic void format_map();
    used_blocks    = '0;
    used_blocks[0] = 1'b1;
  endfunction

  // Applies one command to the predicted map and works out its result.
  function automatic alloc_reply_t predict_reply(cmd_e c, logic [7:0] idx, logic [8:0] req);
    alloc_reply_t r;
    int           run_len;
    int           run_start;
    int           best_diff;
    int           best_start;
    int           total;
    bit           found;
    bit           used;
    r.status   = ST_OK;
    r.index    = '0;
    r.total    = '0;
    run_len    = 0;
    run_start  = 0;
    best_diff  = 0;
    best_start = 0;
    total      = 0;
    found      = 1'b0;
    case (c)
      CMD_ALLOC: begin
        if (idx >= TB_SPAN) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_NOFREE;
          for (int b = int'(idx); b < TB_SPAN; b++) begin
            if (!used_blocks[b]) begin
              used_blocks[b] = 1'b1;
              r.status       = ST_OK;
              r.index        = 8'(b);
              break;
            end
          end
        end
      end
      CMD_FREE: begin
        if (idx >= TB_SPAN) r.status = ST_RANGE;
        else used_blocks[idx] = 1'b0;
      end
      CMD_BEST: begin
        // Walk every free run; the end of the span closes the last one.
        for (int b = 0; b <= TB_SPAN; b++) begin
          used = (b == TB_SPAN) ? 1'b1 : used_blocks[b];
          if (!used) begin
            if (run_len == 0) run_start = b;
            run_len++;
          end else if (run_len > 0) begin
            total += run_len;
            if (run_len >= int'(req)) begin
              if (!found || (run_len - int'(req)) < best_diff) begin
                found      = 1'b1;
                best_diff  = run_len - int'(req);
                best_start = run_start;
              end
            end
            run_len = 0;
          end
        end
        r.total = 9'(total);
        if (found) r.index = 8'(best_start);
        else if (total < int'(req) || total == 0) r.status = ST_NOSPACE;
        else r.status = ST_FRAG;
      end
      default: begin
        format_map();
      end
    endcase
    return r;
  endfunction

  // Offers one command and waits for its transfer; records the expected result.
  task automatic send_item(cmd_e c, logic [7:0] idx, logic [8:0] req, bit typed,
                           alloc_reply_t typed_r);
    alloc_reply_t pred;
    @(negedge clk_i);
    calm = (items_sent >= CALM_LO) && (items_sent < CALM_HI);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    cmd_i            = c;
    block_index_i    = idx;
    request_blocks_i = req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pred = predict_reply(c, idx, req);
    pending_replies.push_back(typed ? typed_r : pred);
    items_sent++;
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  // Request sizes lean small, with some large ones and the maximum.
  function automatic logic [8:0] rand_req();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 9'($urandom_range(0, 12));
    else if (p < 85) return 9'($urandom_range(0, 256));
    else if (p < 95) return 9'($urandom_range(100, 256));
    return 9'd256;
  endfunction

  // Given command with a random request size, the hint supplied by the caller.
  task automatic send_rand(cmd_e c, logic [7:0] idx);
    send_item(c, idx, rand_req(), 1'b0, '0);
  endtask

  // Stops offering until every expected result has come back.
  task automatic drain_wait();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  // Random phases: contiguous fills with holes punched in, or mixed churn.
  task automatic run_random();
    int         phase;
    int         n;
    int         base;
    int unsigned p;
    phase = 0;
    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      phase++;
      if (phase % 8 == 0) drain_wait();
      if ($urandom_range(0, 9) < 4) begin
        // Fill from one hint, often from a word boundary so whole words become used.
        base = $urandom_range(0, 7) * 32;
        if ($urandom_range(0, 3) == 0) base += $urandom_range(0, 31);
        if ($urandom_range(0, 1)) send_rand(CMD_FORMAT, 8'($urandom));
        n = $urandom_range(8, 70);
        repeat (n) send_rand(CMD_ALLOC, 8'(base));
        repeat ($urandom_range(1, 8)) send_rand(CMD_FREE, 8'(base + $urandom_range(0, n)));
        repeat ($urandom_range(2, 6)) send_rand(CMD_BEST, 8'($urandom));
      end else begin
        repeat ($urandom_range(10, 40)) begin
          p = $urandom_range(0, 99);
          if (p < 35) begin
            if ($urandom_range(0, 4) == 0) send_rand(CMD_ALLOC, 8'($urandom_range(200, 255)));
            else send_rand(CMD_ALLOC, 8'($urandom));
          end else if (p < 60) begin
            send_rand(CMD_FREE, 8'($urandom));
          end else if (p < 97) begin
            send_rand(CMD_BEST, 8'($urandom));
          end else begin
            send_rand(CMD_FORMAT, 8'($urandom));
          end
        end
      end
    end
  endtask

  // Receiver: random back-pressure, one long hold-off, none in the calm stretch.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
      end else begin
        out_ready_i = calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Result checker: compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    alloc_reply_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("unexpected result: status %0d index %0d total %0d",
                   status_o, result_index_o, free_total_o);
        mismatches++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (status_o !== exp_r.status || result_index_o !== exp_r.index ||
            free_total_o !== exp_r.total) begin
          if (mismatches < MAX_SHOWN)
            $display("mismatch: status %0d/%0d index %0d/%0d total %0d/%0d (exp/act)",
                     exp_r.status, status_o, exp_r.index, result_index_o,
                     exp_r.total, free_total_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    format_map();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIR_TBL[i].cmd, DIR_TBL[i].idx, DIR_TBL[i].req, DIR_TBL[i].typed,
                '{status: DIR_TBL[i].st, index: DIR_TBL[i].res, total: DIR_TBL[i].tot});
    end
    drain_wait();

    run_random();
    drain_wait();
    repeat (TAIL_LEN) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bbfa_pkg.sv
src/bbfa_ctrl.sv
src/bbfa_datapath.sv
src/bitmap_best_fit_block_allocator.sv
src/bbfa_checker.sv
tb/sv/bitmap_best_fit_block_allocator_tb.sv
